// ===== rtl/line_assembler_trim_defines.svh =====
// ----------------------------------------------------------------------------
// line_assembler_trim_defines
// assertion macros used by the line assembler rtl
// ----------------------------------------------------------------------------
`ifndef LINE_ASSEMBLER_TRIM_DEFINES_SVH
`define LINE_ASSEMBLER_TRIM_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on every rising clock edge outside reset
`define LAT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// checked on every rising clock edge, reset included
`define LAT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define LAT_ASSERT(lbl, prop, msg)
`define LAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/lat_pkg.sv =====
// ----------------------------------------------------------------------------
// lat_pkg
// shared constants, types and helpers of the line assembler
// ----------------------------------------------------------------------------
package lat_pkg;

   localparam int LINE_BYTES_DEF = 64;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_HT = 8'h09;
   localparam logic [7:0] CH_VT = 8'h0B;
   localparam logic [7:0] CH_FF = 8'h0C;

   localparam logic [15:0] OVF_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } lat_state_type;

   // whitespace that is trimmed from both ends of a line
   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == CH_SP) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF);
   endfunction

endpackage

// ===== rtl/lat_line_ram.sv =====
// ----------------------------------------------------------------------------
// lat_line_ram
// line buffer storage, one write and one registered read port
// ----------------------------------------------------------------------------
module lat_line_ram import lat_pkg::*; #(
   parameter int LINE_BYTES = LINE_BYTES_DEF,
   parameter int AW         = $clog2(LINE_BYTES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [LINE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/line_assembler_trim.sv =====
// ----------------------------------------------------------------------------
// line_assembler_trim
// assembles received bytes into command lines and emits them trimmed
// ----------------------------------------------------------------------------
// Each received byte is taken while the block is idle. Carriage returns are
// dropped, other bytes go into a LINE_BYTES deep line buffer, and the first
// and last non-whitespace positions are tracked as bytes arrive, so no scan
// is needed at line end. A line feed starts the readout: the trimmed line
// comes out one byte per transaction with rsp_line_end on the final byte,
// each byte passing through the single buffer read port (address, then
// load into the output register, which waits while the receiver stalls);
// req_stall stays high from the line feed until the last byte is loaded.
// The last byte may still wait in the output register while new bytes are
// already taken. An empty or all-whitespace line emits nothing. A byte that
// would fill the buffer (LINE_BYTES-1 bytes already held) bumps the
// saturating overflow count and the rest of that line up to its line feed is
// dropped. Every result carries the overflow count in rsp_overflow_lines.
// ----------------------------------------------------------------------------
`include "line_assembler_trim_defines.svh"

module line_assembler_trim import lat_pkg::*; #(
   parameter int LINE_BYTES = LINE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // received byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // trimmed line channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_line_byte,
   output logic        rsp_line_end,
   output logic [15:0] rsp_overflow_lines
);

   localparam int AW = $clog2(LINE_BYTES);
   localparam logic [AW-1:0] FILL_MAX = AW'(LINE_BYTES - 1);

   // sequencer and line bookkeeping
   lat_state_type state_ff, state_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic          discard_ff, discard_in;
   logic          has_data_ff, has_data_in;   // a non-whitespace byte is held
   logic [AW-1:0] head_ff, head_in;           // first non-whitespace position
   logic [AW-1:0] tail_ff, tail_in;           // last non-whitespace position
   logic [AW-1:0] ptr_ff, ptr_in;             // readout position
   logic [15:0]   ovf_ff, ovf_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_end_ff, rsp_end_in;
   logic [15:0]   rsp_ovf_ff, rsp_ovf_in;

   // buffer ports
   logic          wr_en;
   logic          rd_en;
   logic [7:0]    rd_data;

   logic          req_take;
   logic          rsp_take;
   logic          out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   // the output register can load when empty or emptied this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   lat_line_ram #(
      .LINE_BYTES (LINE_BYTES),
      .AW         (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         discard_ff   <= 1'b0;
         has_data_ff  <= 1'b0;
         ovf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         discard_ff   <= discard_in;
         has_data_ff  <= has_data_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      ptr_ff      <= ptr_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      discard_in   = discard_ff;
      has_data_in  = has_data_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ptr_in       = ptr_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_rx_byte == CH_CR) begin
                  // carriage return is dropped in every state
               end else if (req_rx_byte == CH_LF) begin
                  fill_in     = '0;
                  has_data_in = 1'b0;
                  if (discard_ff) begin
                     discard_in = 1'b0;
                  end else if (has_data_ff) begin
                     // start readout of the trimmed span
                     ptr_in   = head_ff;
                     state_in = ST_READ;
                  end
               end else if (discard_ff) begin
                  // rest of an overflowed line is dropped
               end else if (fill_ff == FILL_MAX) begin
                  if (ovf_ff != OVF_MAX) begin
                     ovf_in = ovf_ff + 16'd1;
                  end
                  discard_in  = 1'b1;
                  fill_in     = '0;
                  has_data_in = 1'b0;
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + AW'(1);
                  if (!is_blank(req_rx_byte)) begin
                     tail_in = fill_ff;
                     if (!has_data_ff) begin
                        head_in     = fill_ff;
                        has_data_in = 1'b1;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data;
               rsp_end_in   = (ptr_ff == tail_ff);
               rsp_ovf_in   = ovf_ff;
               if (ptr_ff == tail_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff + AW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_byte      = rsp_byte_ff;
   assign rsp_line_end       = rsp_end_ff;
   assign rsp_overflow_lines = rsp_ovf_ff;

   // trimmed span lies inside the held bytes while collecting
   `LAT_ASSERT(a_span_in_fill, (state_ff == ST_IDLE && has_data_ff) |-> (head_ff <= tail_ff && tail_ff < fill_ff), "trimmed span outside held bytes")
   // a discarded line holds nothing
   `LAT_ASSERT(a_discard_empty, discard_ff |-> (!has_data_ff && fill_ff == '0), "bytes held while discarding")
   // readout never walks past the last kept byte
   `LAT_ASSERT(a_ptr_bound, (state_ff != ST_IDLE) |-> (ptr_ff <= tail_ff && !discard_ff), "readout past end of line")
   // overflow count only steps up by one
   `LAT_ASSERT(a_ovf_step, (ovf_ff != $past(ovf_ff)) |-> (ovf_ff == $past(ovf_ff) + 16'd1), "overflow count jumped")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the trimmed command line assembler
// ----------------------------------------------------------------------------
// Received bytes are pushed through the input channel. A short directed
// table comes first, then random lines with random content. Every accepted
// byte also runs through a line predictor kept inside the bench. The
// predictor queues the trimmed characters each line feed should produce,
// and every transaction on the result channel is compared field by field
// against the oldest queued character. The random lines include lines that
// fill the buffer exactly and lines that overflow it. Both channels idle at
// random in the table and the first two of the three phases of traffic.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lat_pkg::*;

   localparam int LINE_CAP     = LINE_BYTES_DEF;
   localparam int PHASE_ITEMS  = 130;   // three phases, about 430 bytes with the table
   localparam int DRAIN_CYCLES = 40;
   localparam int SHOWN_ERRORS = 10;

   // one emitted character as the result channel carries it
   typedef struct packed {
      logic [7:0]  ch;
      logic        line_end;
      logic [15:0] ovf;
   } line_char_type;

   // directed stimulus row: a byte, plus a hand-typed result where obvious
   typedef struct packed {
      logic [7:0]    rx;
      logic          typed;     // expectation below replaces the prediction
      logic          has_char;  // typed row emits exactly one character
      line_char_type want;
   } dir_row_type;

   localparam int DIR_ROWS = 23;
   localparam line_char_type NO_CHAR = '0;

   dir_row_type dir_table [DIR_ROWS] = '{
      // line feed straight after reset: empty line, nothing comes out
      '{CH_LF, 1'b1, 1'b0, NO_CHAR},
      // lone carriage return is ignored
      '{CH_CR, 1'b1, 1'b0, NO_CHAR},
      // all-zero and all-one bytes are ordinary data
      '{8'h00, 1'b0, 1'b0, NO_CHAR},
      '{8'hFF, 1'b0, 1'b0, NO_CHAR},
      '{CH_LF, 1'b0, 1'b0, NO_CHAR},
      // every whitespace kind trimmed around a single character
      '{CH_SP, 1'b0, 1'b0, NO_CHAR},
      '{CH_HT, 1'b0, 1'b0, NO_CHAR},
      '{8'h5A, 1'b0, 1'b0, NO_CHAR},
      '{CH_VT, 1'b0, 1'b0, NO_CHAR},
      '{CH_FF, 1'b0, 1'b0, NO_CHAR},
      '{CH_LF, 1'b1, 1'b1, '{8'h5A, 1'b1, 16'h0000}},
      // whitespace-only line emits nothing
      '{CH_SP, 1'b0, 1'b0, NO_CHAR},
      '{CH_FF, 1'b0, 1'b0, NO_CHAR},
      '{CH_LF, 1'b1, 1'b0, NO_CHAR},
      // carriage returns inside a line vanish, inner blank is kept
      '{8'h61, 1'b0, 1'b0, NO_CHAR},
      '{CH_CR, 1'b0, 1'b0, NO_CHAR},
      '{CH_SP, 1'b0, 1'b0, NO_CHAR},
      '{8'h62, 1'b0, 1'b0, NO_CHAR},
      '{CH_CR, 1'b0, 1'b0, NO_CHAR},
      '{CH_LF, 1'b0, 1'b0, NO_CHAR},
      // values around the sign bit
      '{8'h7F, 1'b0, 1'b0, NO_CHAR},
      '{8'h80, 1'b0, 1'b0, NO_CHAR},
      '{CH_LF, 1'b0, 1'b0, NO_CHAR}
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [7:0]  rsp_line_byte;
   logic        rsp_line_end;
   logic [15:0] rsp_overflow_lines;

   // idle rates of the two sides, changed per phase
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;

   int bytes_sent   = 0;
   int mismatches   = 0;

   // line predictor state
   logic [7:0]  held_bytes [LINE_CAP];
   int          held_count    = 0;
   logic        dropping_line = 1'b0;
   logic [15:0] overflow_seen = '0;

   line_char_type fresh_chars [$];   // characters released by the latest byte
   line_char_type pending_chars [$]; // characters still owed by the block

   line_assembler_trim #(
      .LINE_BYTES(LINE_CAP)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_line_byte(rsp_line_byte),
      .rsp_line_end(rsp_line_end),
      .rsp_overflow_lines(rsp_overflow_lines)
   );

   always #5 clock = ~clock;

   // only these four count as blanks for trimming
   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SP) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF);
   endfunction

   // advance the line predictor by one received byte
   function automatic void assemble_byte(input logic [7:0] c);
      int lead;
      int stop;
      fresh_chars.delete();
      if (c == CH_CR) begin
         return;  // ignored in every state
      end
      if (c == CH_LF) begin
         if (dropping_line) begin
            // end of an overflowed line: nothing comes out
            dropping_line = 1'b0;
            held_count = 0;
            return;
         end
         lead = 0;
         while (lead < held_count && is_ws(held_bytes[lead])) lead++;
         stop = held_count;
         while (stop > lead && is_ws(held_bytes[stop - 1])) stop--;
         for (int i = lead; i < stop; i++) begin
            fresh_chars.push_back(line_char_type'{held_bytes[i], (i == stop - 1),
                                                  overflow_seen});
         end
         held_count = 0;
         return;
      end
      if (dropping_line) begin
         return;
      end
      if (held_count + 1 >= LINE_CAP) begin
         // byte would fill the buffer: count the overflow, drop the line
         if (overflow_seen != OVF_MAX) overflow_seen++;
         dropping_line = 1'b1;
         held_count = 0;
         return;
      end
      held_bytes[held_count] = c;
      held_count++;
   endfunction

   // one transaction on the received byte channel, with random idle first
   task automatic send_rx(input logic [7:0] b, input logic typed = 1'b0,
                          input logic has_char = 1'b0,
                          input line_char_type want = '0);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      // accepted at this edge
      assemble_byte(b);
      if (typed) begin
         if (has_char) pending_chars.push_back(want);
      end else begin
         foreach (fresh_chars[k]) pending_chars.push_back(fresh_chars[k]);
      end
      bytes_sent++;
   endtask

   // line content: blanks and carriage returns mixed into random data
   function automatic logic [7:0] draw_char(input int blank_pct);
      logic [7:0] blanks [4] = '{CH_SP, CH_HT, CH_VT, CH_FF};
      logic [7:0] c;
      int r;
      r = $urandom_range(0, 99);
      if (r < blank_pct) return blanks[$urandom_range(0, 3)];
      if (r < blank_pct + 5) return CH_CR;
      do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
      return c;
   endfunction

   task automatic send_line(input int len, input int blank_pct);
      repeat (len) send_rx(draw_char(blank_pct));
      send_rx(CH_LF);
   endtask

   // one traffic phase: a long line first, then mostly well-formed short lines,
   // some lines near the buffer size, and raw noise that may carry line feeds anywhere
   task automatic run_phase(input int tx_pct, input int rx_pct,
                            input int long_lo, input int long_hi);
      int start;
      int kind;
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      start = bytes_sent;
      send_line($urandom_range(long_lo, long_hi), 0);
      while (bytes_sent - start < PHASE_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 12) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 4) == 0) send_rx(CH_LF);
               else send_rx(8'($urandom_range(0, 255)));
            end
         end else if (kind < 15) begin
            send_line($urandom_range(LINE_CAP - 4, LINE_CAP + 4), 10);
         end else begin
            send_line($urandom_range(0, 14), 25);
         end
      end
   endtask

   function automatic void flag_mismatch(input string what, input int want,
                                         input int got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
         $display("mismatch at %0t: %s expected 0x%0h actual 0x%0h",
                  $realtime, what, want, got);
      end
   endfunction

   // result side: random stall, and check every accepted transaction
   always @(posedge clock) begin
      line_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            flag_mismatch("unexpected line_byte", 0, rsp_line_byte);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_line_byte !== want.ch) begin
               flag_mismatch("line_byte", want.ch, rsp_line_byte);
            end
            if (rsp_line_end !== want.line_end) begin
               flag_mismatch("line_end", want.line_end, rsp_line_end);
            end
            if (rsp_overflow_lines !== want.ovf) begin
               flag_mismatch("overflow_lines", want.ovf, rsp_overflow_lines);
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
   end

   initial begin
      tx_idle_pct  = 31;
      rx_stall_pct = 56;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_table[r]) begin
         send_rx(dir_table[r].rx, dir_table[r].typed, dir_table[r].has_char,
                 dir_table[r].want);
      end

      // random traffic: a full buffer line, then overflowing lines, then mixed
      run_phase(31, 56, LINE_CAP - 1, LINE_CAP - 1);
      run_phase(56, 31, LINE_CAP + 2, LINE_CAP + 8);
      run_phase(0, 0, LINE_CAP - 4, LINE_CAP + 6);

      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lat_pkg.sv
rtl/lat_line_ram.sv
rtl/line_assembler_trim.sv
tb/tb_top.sv
